FILE: design/raster_to_block_tiler_unit_macros.svh
// Assertion macros for the raster to block tiler.
// Included by the top level only; expects aclk and aresetn in scope.
`ifndef RASTER_TO_BLOCK_TILER_UNIT_MACROS_SVH
`define RASTER_TO_BLOCK_TILER_UNIT_MACROS_SVH

// Same-cycle implication, ignored while in reset
`define RTBT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while in reset
`define RTBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rtbt_pkg.sv
// Shared types and constants for the raster to block tiler.
// No dependencies; imported by every module of the block.
`default_nettype none
package rtbt_pkg;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int QDEPTH        = 4;
    localparam int QAW           = 2;
    localparam int QCW           = 3;

    // register indexes of the configuration port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DROP   = 2'd2;

    // one finished block, pix[row][col]
    typedef struct packed {
        logic [8:0]             bx;
        logic [13:0]            by;
        logic                   solid;
        logic [3:0][3:0][31:0]  pix;
    } blk_entry_t;

    // queue status seen by the front end
    typedef struct packed {
        logic           empty;
        logic [QCW-1:0] count;
    } q_stat_t;

    // result item as packed into tdata, lowest field last
    typedef struct packed {
        logic [31:0] pix_d;
        logic [31:0] pix_c;
        logic [31:0] pix_b;
        logic [31:0] pix_a;
        logic [1:0]  block_row;
        logic [13:0] block_y;
        logic [8:0]  block_x;
    } out_item_t;

endpackage
`default_nettype wire

FILE: design/rtbt_front.sv
// Front end: configuration registers, raster counters, four banked line stores
// and block assembly with solid detection. Depends on rtbt_pkg.
`default_nettype none
module rtbt_front
    import rtbt_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire q_stat_t     q_stat,
    output logic             push,
    output blk_entry_t       push_entry,
    output logic             drop_solid
);

    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int EW         = (WW > 12) ? WW : 12;
    localparam int BANK_DEPTH = ((MAX_WIDTH + 3) / 4 < 2) ? 2 : (MAX_WIDTH + 3) / 4;
    localparam int AW         = $clog2(BANK_DEPTH);
    localparam int RST_W      = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;

    logic [WW-1:0]        w_eff_reg;
    logic [15:0]          h_eff_reg;
    logic                 drop_reg;
    logic [WW-1:0]        col_reg;
    logic [15:0]          row_reg;
    logic [3:0][31:0]     word_reg;
    logic                 s1_valid_reg;
    logic [AW-1:0]        s1_bx_reg;
    logic [13:0]          s1_by_reg;
    logic [1:0]           s1_band_reg;
    logic [127:0]         s1_cur_reg;
    logic [127:0]         rd_data [4];

    logic                 accept;
    logic [1:0]           band;
    logic [1:0]           lane;
    logic                 last_col;
    logic                 last_row;
    logic                 word_done;
    logic                 trigger;
    logic [AW-1:0]        addr;
    logic [3:0][31:0]     full_word;
    logic [EW-1:0]        w_in;
    logic [WW-1:0]        w_next;
    logic [3:0][3:0][31:0] blk;
    logic                 solid;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (q_stat.count + QCW'(s1_valid_reg)) < QCW'(QDEPTH);
    assign band     = row_reg[1:0];
    assign lane     = col_reg[1:0];
    assign last_col = (col_reg == w_eff_reg - WW'(1));
    assign last_row = (row_reg == h_eff_reg - 16'd1);
    assign word_done = (lane == 2'd3) || last_col;
    assign trigger  = ((band == 2'd3) || last_row) && word_done;
    assign addr     = col_reg[AW+1:2];
    assign drop_solid = drop_reg;

    // width register value: zero acts as one, saturates at the store width
    always_comb begin
        w_in = EW'(cfg_wdata[11:0]);
        if (w_in == '0) begin
            w_next = WW'(1);
        end else if (w_in > EW'(MAX_WIDTH)) begin
            w_next = WW'(MAX_WIDTH);
        end else begin
            w_next = WW'(w_in);
        end
    end

    // current block row, right edge padded with the last real pixel
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            full_word[i] = (2'(i) < lane) ? word_reg[i] : s_tdata;
        end
    end

    // line store banks, one per band row
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [127:0] mem [BANK_DEPTH];
        always_ff @(posedge aclk) begin
            if (accept && word_done && band == 2'(b)) begin
                mem[addr] <= full_word;
            end
            rd_data[b] <= mem[addr];
        end
    end

    // configuration, counters and block capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_eff_reg    <= WW'(RST_W);
            h_eff_reg    <= 16'hFFFF;
            drop_reg     <= 1'b1;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept && trigger;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_WIDTH: begin
                        w_eff_reg <= w_next;
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    REG_HEIGHT: begin
                        h_eff_reg <= (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    REG_DROP: drop_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end else if (accept) begin
                if (last_col) begin
                    col_reg <= '0;
                    row_reg <= last_row ? 16'd0 : row_reg + 16'd1;
                end else begin
                    col_reg <= col_reg + WW'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            word_reg[lane] <= s_tdata;
            s1_bx_reg      <= addr;
            s1_by_reg      <= row_reg[15:2];
            s1_band_reg    <= band;
            s1_cur_reg     <= full_word;
        end
    end

    // rows past the current one repeat it; solid check over all 16
    always_comb begin
        solid = 1'b1;
        for (int r = 0; r < 4; r++) begin
            blk[r] = (2'(r) < s1_band_reg) ? rd_data[r] : s1_cur_reg;
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (blk[r][c] != blk[0][0]) solid = 1'b0;
            end
        end
    end

    assign push             = s1_valid_reg;
    assign push_entry.bx    = 9'(s1_bx_reg);
    assign push_entry.by    = s1_by_reg;
    assign push_entry.solid = solid;
    assign push_entry.pix   = blk;

endmodule
`default_nettype wire

FILE: design/rtbt_queue.sv
// Short block queue between front and back ends.
// Depends on rtbt_pkg.
`default_nettype none
module rtbt_queue
    import rtbt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire blk_entry_t push_entry,
    input  wire logic       pop,
    output blk_entry_t      head,
    output q_stat_t         q_stat
);

    blk_entry_t     slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;

    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.count = count_reg;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            count_reg <= count_reg + QCW'(push) - QCW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule
`default_nettype wire

FILE: design/rtbt_back.sv
// Back end: splits a queued block into result items behind an output register.
// Depends on rtbt_pkg.
`default_nettype none
module rtbt_back
    import rtbt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire blk_entry_t head,
    input  wire q_stat_t    q_stat,
    input  wire logic       drop_solid,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [159:0]    m_tdata,   // block_x, block_y, block_row, pix_a..pix_d
    output logic            m_tuser,   // solid
    output logic            m_tlast
);

    logic [1:0]  row_reg;
    logic        m_valid_reg;
    out_item_t   item_reg;
    logic        solid_reg;
    logic        last_reg;
    logic        load;
    logic        drop;

    assign load = !m_valid_reg || m_tready;
    assign drop = head.solid && drop_solid;
    assign pop  = load && !q_stat.empty && (drop || row_reg == 2'd3);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, item_reg};
    assign m_tuser  = solid_reg;
    assign m_tlast  = last_reg;

    // item sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            row_reg     <= 2'd0;
        end else if (load) begin
            m_valid_reg <= !q_stat.empty;
            if (!q_stat.empty) begin
                row_reg <= drop ? 2'd0 : row_reg + 2'd1;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (load && !q_stat.empty) begin
            item_reg.block_x <= head.bx;
            item_reg.block_y <= head.by;
            solid_reg        <= head.solid;
            if (drop) begin
                item_reg.block_row <= 2'd0;
                item_reg.pix_a     <= head.pix[0][0];
                item_reg.pix_b     <= '0;
                item_reg.pix_c     <= '0;
                item_reg.pix_d     <= '0;
                last_reg           <= 1'b1;
            end else begin
                item_reg.block_row <= row_reg;
                item_reg.pix_a     <= head.pix[row_reg][0];
                item_reg.pix_b     <= head.pix[row_reg][1];
                item_reg.pix_c     <= head.pix[row_reg][2];
                item_reg.pix_d     <= head.pix[row_reg][3];
                last_reg           <= (row_reg == 2'd3);
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/raster_to_block_tiler_unit.sv
// Raster to 4x4 block tiler: accepts one pixel per cycle. A finished block passes
// through the front-end s1 registers, the queue and the output register; it
// gives four items, one per cycle unless stalled (one for a dropped solid block).
// Input stalls only once the four-block queue fills: blocks ending faster than one
// per four pixels (narrow images, right-edge partial blocks in back-to-back last
// rows) or a stalled receiver. Synchronous active-low reset clears counters, flags
// and queue pointers and sets default settings; line store, payload not cleared.
// Depends on rtbt_pkg, rtbt_front, rtbt_queue, rtbt_back.
`default_nettype none
`include "raster_to_block_tiler_unit_macros.svh"
module raster_to_block_tiler_unit
    import rtbt_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // pixel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [159:0]      m_tdata,   // block_x, block_y, block_row, pix_a..pix_d
    output logic              m_tuser,   // solid
    output logic              m_tlast
);

    logic       push;
    logic       pop;
    logic       drop_solid;
    blk_entry_t push_entry;
    blk_entry_t head;
    q_stat_t    q_stat;

    rtbt_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry),
        .drop_solid (drop_solid)
    );

    rtbt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    rtbt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .q_stat     (q_stat),
        .drop_solid (drop_solid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // queue never overflows or underflows
    `RTBT_ASSERT_IMPL(a_push_room, push && !pop, q_stat.count < QCW'(QDEPTH), "queue overflow")
    `RTBT_ASSERT_IMPL(a_pop_held, pop, !q_stat.empty, "pop from empty queue")
    // an accepted item always finds room for its block
    `RTBT_ASSERT_NEXT(a_ready_room, s_tvalid && s_tready, q_stat.count < QCW'(QDEPTH),
        "accepted item without queue room")

endmodule
`default_nettype wire

FILE: tb/sv/tb_raster_to_block_tiler_unit.sv
// Testbench for raster_to_block_tiler_unit: sends pixel images and checks every
// block row item against a built-in tiler predictor. Depends on rtbt_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_raster_to_block_tiler_unit;
    import rtbt_pkg::*;

    localparam int LINE_W      = 2048;
    localparam int CYCLE_LIMIT = 100000;
    localparam int DRAIN_WAIT  = 12;

    typedef struct packed {
        out_item_t item;
        logic      solid;
        logic      last;
    } blk_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_addr = REG_WIDTH;
    logic [15:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;   // pixel
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;        // block_x, block_y, block_row, pix_a..pix_d
    logic         m_tuser;        // solid
    logic         m_tlast;

    // predictor state
    logic [31:0]  line_mem [0:4*LINE_W-1];
    logic [11:0]  img_w;
    logic [15:0]  img_h;
    logic         drop_sol;
    int unsigned  px_col, px_row;
    blk_row_t     blk_rows_q[$];

    int unsigned  errors = 0;
    int unsigned  cycles = 0;
    int unsigned  pixels_sent = 0;
    int unsigned  rows_seen = 0;
    int unsigned  solid_seen = 0;
    int unsigned  hold_left = 0;
    int unsigned  hold_len = 0;
    int unsigned  hold_seq = 0;
    int unsigned  hold_ack = 0;
    bit           no_idle = 0;

    raster_to_block_tiler_unit dut (.*);

    always #5 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // work out the block rows that one accepted pixel releases
    function automatic void tile_pixel(logic [31:0] p);
        int unsigned w, h, col, row, br, bx, by, sr, sc;
        logic [31:0] blk [4][4];
        bit sol;
        blk_row_t e;
        w = (img_w == 0) ? 1 : ((img_w > LINE_W) ? LINE_W : img_w);
        h = (img_h == 0) ? 1 : img_h;
        col = px_col;
        row = px_row;
        if (col >= w) col = w - 1;
        br = row & 3;
        line_mem[br*LINE_W + col] = p;
        if ((br == 3 || row + 1 >= h) && ((col & 3) == 3 || col + 1 >= w)) begin
            bx = col >> 2;
            by = row >> 2;
            sol = 1;
            for (int r = 0; r < 4; r++) begin
                sr = (r < br) ? r : br;
                for (int c = 0; c < 4; c++) begin
                    sc = bx*4 + c;
                    if (sc > w - 1) sc = w - 1;
                    blk[r][c] = line_mem[sr*LINE_W + sc];
                    if (blk[r][c] != blk[0][0]) sol = 0;
                end
            end
            e.item.block_x = bx[8:0];
            e.item.block_y = by[13:0];
            if (sol && drop_sol) begin
                e.item.block_row = 2'd0;
                e.item.pix_a = blk[0][0];
                e.item.pix_b = '0;
                e.item.pix_c = '0;
                e.item.pix_d = '0;
                e.solid = 1'b1;
                e.last = 1'b1;
                blk_rows_q.push_back(e);
            end else begin
                for (int r = 0; r < 4; r++) begin
                    e.item.block_row = r[1:0];
                    e.item.pix_a = blk[r][0];
                    e.item.pix_b = blk[r][1];
                    e.item.pix_c = blk[r][2];
                    e.item.pix_d = blk[r][3];
                    e.solid = sol;
                    e.last = (r == 3);
                    blk_rows_q.push_back(e);
                end
            end
        end
        if (col + 1 >= w) begin
            px_col = 0;
            px_row = (row + 1 >= h) ? 0 : ((row + 1) & 16'hFFFF);
        end else begin
            px_col = col + 1;
        end
    endfunction

    function automatic bit field_ok(string name, logic [31:0] e, logic [31:0] g);
        if (e !== g) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, g);
            return 0;
        end
        return 1;
    endfunction

    // result side: random stalls, long hold-off on request, checking
    always @(posedge aclk) begin
        automatic int unsigned stall = 0;
        automatic out_item_t got;
        automatic blk_row_t e;
        automatic bit ok;
        if (aresetn && m_tvalid && m_tready) begin
            got = out_item_t'(m_tdata[152:0]);
            if (blk_rows_q.size() == 0) begin
                $display("%0t: unexpected item, actual %h", $time, m_tdata);
                errors++;
            end else begin
                e = blk_rows_q.pop_front();
                ok = 1;
                ok &= field_ok("block_x", e.item.block_x, got.block_x);
                ok &= field_ok("block_y", e.item.block_y, got.block_y);
                ok &= field_ok("block_row", e.item.block_row, got.block_row);
                ok &= field_ok("pix_a", e.item.pix_a, got.pix_a);
                ok &= field_ok("pix_b", e.item.pix_b, got.pix_b);
                ok &= field_ok("pix_c", e.item.pix_c, got.pix_c);
                ok &= field_ok("pix_d", e.item.pix_d, got.pix_d);
                ok &= field_ok("solid", e.solid, m_tuser);
                ok &= field_ok("last", e.last, m_tlast);
                if (!ok) errors++;
                rows_seen++;
                if (e.solid) solid_seen++;
            end
        end
        if (hold_ack != hold_seq) begin
            // a test asked for a hold-off: start counting it here
            hold_ack <= hold_seq;
            hold_left <= hold_len;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else begin
            stall = $urandom_range(0, 99);
            m_tready <= !(stall < 25 || (!m_tready && stall < 60));
        end
    end

    function automatic int unsigned gap_len();
        int unsigned d;
        if (no_idle) return 0;
        d = $urandom_range(0, 99);
        if (d < 60) return 0;
        if (d < 93) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // offer one pixel and wait until it is taken
    task automatic send_pixel(logic [31:0] p);
        int unsigned g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tile_pixel(p);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (blk_rows_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // one register write; the enable is dropped again before the next write
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_WIDTH: begin
                img_w = val[11:0];
                px_col = 0;
                px_row = 0;
            end
            REG_HEIGHT: begin
                img_h = val;
                px_col = 0;
                px_row = 0;
            end
            REG_DROP: drop_sol = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, bit drop);
        wait_idle();
        write_reg(REG_WIDTH, w[15:0]);
        write_reg(REG_HEIGHT, h[15:0]);
        write_reg(REG_DROP, {15'd0, drop});
    endtask

    // one image; pal_pct percent of pixels come from a two-colour palette
    task automatic send_image(int unsigned w, int unsigned h, int unsigned pal_pct);
        logic [31:0] c0, c1;
        c0 = $urandom;
        c1 = $urandom;
        for (int i = 0; i < w*h; i++) begin
            if ($urandom_range(0, 99) < pal_pct)
                send_pixel($urandom_range(0, 3) == 0 ? c1 : c0);
            else
                send_pixel($urandom);
        end
    endtask

    // right-edge pad, short bottom band, extremes of the pixel value
    task automatic test_edge_padding();
        set_geometry(5, 3, 0);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        for (int i = 0; i < 13; i++) send_pixel($urandom);
    endtask

    // all-equal block, dropped and kept
    task automatic test_solid_blocks();
        set_geometry(4, 4, 1);
        for (int i = 0; i < 16; i++) send_pixel(32'hA5A5_5A5A);
        wait_idle();
        write_reg(REG_DROP, 16'd0);
        for (int i = 0; i < 16; i++) send_pixel(32'hFFFF_FFFF);
    endtask

    // width and height of zero act as one; unknown index is ignored
    task automatic test_zero_geometry();
        set_geometry(0, 0, 0);
        write_reg(2'd3, 16'hFFFF);
        send_pixel(32'h1234_5678);
        send_pixel($urandom);
        wait_idle();
        write_reg(REG_DROP, 16'hFFFF);
        send_pixel($urandom);
    endtask

    // width beyond the store saturates; start of a long single row
    task automatic test_wide_row();
        set_geometry(16'hFFFF, 1, 1);
        send_image(32, 1, 85);
    endtask

    // top of the tallest image, one column, every band solid
    task automatic test_tall_image();
        logic [31:0] c;
        set_geometry(1, 65535, 1);
        no_idle = 1;
        c = $urandom;
        for (int r = 0; r < 32; r++) begin
            if ((r & 3) == 0) c = $urandom;
            if (r == 12) no_idle = 0;
            if (r == 20) no_idle = 1;
            send_pixel(c);
        end
        no_idle = 0;
    endtask

    task automatic test_random_images();
        int unsigned w, h;
        while (pixels_sent < 190) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            set_geometry(w, h, $urandom_range(0, 1));
            no_idle = ($urandom_range(0, 3) == 0);
            send_image(w, h, $urandom_range(0, 100));
            no_idle = 0;
        end
    endtask

    // receiver holds off while pixels keep coming, so the block stalls its input
    task automatic test_backpressure();
        set_geometry(4, 24, 0);
        hold_len = 400;
        hold_seq++;
        no_idle = 1;
        send_image(4, 24, 20);
        no_idle = 0;
    endtask

    initial begin
        img_w = 12'd2048;
        img_h = 16'hFFFF;
        drop_sol = 1'b1;
        px_col = 0;
        px_row = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edge_padding();
        test_solid_blocks();
        test_zero_geometry();
        test_wide_row();
        test_tall_image();
        test_random_images();
        test_backpressure();
        wait_idle();
        repeat (20) @(posedge aclk);
        $display("Covered %0d pixels over edge, solid, zero, wide, tall and random images,",
                 pixels_sent);
        $display("with back-pressure; %0d block rows checked, %0d of them solid.",
                 rows_seen, solid_seen);
        if (errors == 0 && blk_rows_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
